@@ hw/rtl/pool_2x2_min_or_average_top_assert.svh @@
// Assertion macros for the pooling block's checker.
`ifndef POOL_2X2_MIN_OR_AVERAGE_TOP_ASSERT_SVH
`define POOL_2X2_MIN_OR_AVERAGE_TOP_ASSERT_SVH

// Property checked at every edge outside reset.
`define P2MA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Property checked at every edge, reset included.
`define P2MA_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/p2ma_pkg.sv @@
package p2ma_pkg;

    // register indexes
    localparam int               CFG_IDX_BITS     = 2;
    localparam int               CFG_DATA_BITS    = 16;
    localparam logic [1:0]       CFG_POOL_MODE    = 2'd0;
    localparam logic [1:0]       CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [1:0]       CFG_FRAME_HEIGHT = 2'd2;

    // pool_mode codes
    localparam logic             MODE_AVG = 1'b0;
    localparam logic             MODE_MIN = 1'b1;

    localparam int               WIDTH_BITS  = 11;
    localparam int               HEIGHT_BITS = 16;
    localparam logic [10:0]      WIDTH_RST   = 11'd1024;
    localparam logic [15:0]      HEIGHT_RST  = 16'd1024;

    localparam int               OUT_BITS = 16;

    // where the current item sits in the frame
    typedef struct packed {
        logic odd_col;
        logic odd_row;
        logic last;
    } t_pos;

endpackage

@@ hw/rtl/p2ma_seq.sv @@
module p2ma_seq
    import p2ma_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int IW       = 9
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_step,
    output logic                     o_mode,
    output t_pos                     o_pos,
    output logic [IW-1:0]            o_idx
);

    localparam int CW = ($clog2(MAX_COLS) > 2) ? $clog2(MAX_COLS) : 2;
    localparam int EW = ($clog2(MAX_COLS + 1) > WIDTH_BITS) ? $clog2(MAX_COLS + 1) : WIDTH_BITS;
    localparam logic [EW-1:0] MAXW = EW'(MAX_COLS);

    logic                   r_mode;
    logic [WIDTH_BITS-1:0]  r_width;
    logic [HEIGHT_BITS-1:0] r_height;
    logic [CW-1:0]          r_col,  n_col;
    logic [HEIGHT_BITS-1:0] r_row,  n_row;

    logic [EW-1:0]          w_fw, w_effw, w_colx, w_col_inc;
    logic [HEIGHT_BITS-1:0] w_effh;
    logic [HEIGHT_BITS:0]   w_row_inc;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_AVG;
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_POOL_MODE:    r_mode   <= i_cfg_data[0];
                CFG_FRAME_WIDTH:  r_width  <= i_cfg_data[WIDTH_BITS-1:0];
                CFG_FRAME_HEIGHT: r_height <= i_cfg_data[HEIGHT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // clamp to the usable range
    always_comb begin
        w_fw      = EW'(r_width);
        w_effw    = (w_fw < EW'(2)) ? EW'(2) : ((w_fw > MAXW) ? MAXW : w_fw);
        w_effh    = (r_height < HEIGHT_BITS'(2)) ? HEIGHT_BITS'(2) : r_height;
        w_colx    = EW'(r_col);
        w_col_inc = w_colx + EW'(1);
        w_row_inc = {1'b0, r_row} + (HEIGHT_BITS + 1)'(1);
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_col_inc >= w_effw) begin
            n_col = '0;
            n_row = (w_row_inc >= {1'b0, w_effh}) ? '0 : w_row_inc[HEIGHT_BITS-1:0];
        end else begin
            n_col = w_col_inc[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_step) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_comb begin
        o_mode        = r_mode;
        o_pos.odd_col = r_col[0];
        o_pos.odd_row = r_row[0];
        // last window: bottom-right pair of the even-sized part of the frame
        o_pos.last    = (r_row == ((w_effh & ~HEIGHT_BITS'(1)) - HEIGHT_BITS'(1)))
                     && (w_colx == ((w_effw & ~EW'(1)) - EW'(1)));
        o_idx         = r_col[IW:1];
    end

endmodule

@@ hw/rtl/p2ma_line.sv @@
module p2ma_line
    import p2ma_pkg::*;
#(
    parameter int DEPTH = 512,
    parameter int IW    = 9,
    parameter int DW    = 17
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [IW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/pool_2x2_min_or_average_top.sv @@
// 2x2 stride-2 pooling (min or floor average) over a raster sample stream.
// Path: input reg -> line store read -> result reg. Throughput: one sample per
//   cycle while the result output is not stalled; each sample costs at most
//   one line store access.
// Reset (synchronous, active low) clears counters and valids, loads config defaults;
//   the line store is not cleared, every entry is written before it is read.
module pool_2x2_min_or_average_top
    import p2ma_pkg::*;
#(
    parameter int MAX_COLS    = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      i_cfg_data,
    // sample in
    input  logic                          i_sample_valid,
    output logic                          o_sample_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    // result out
    output logic                          o_result_valid,
    input  logic                          i_result_ready,
    output logic signed [OUT_BITS-1:0]    o_pooled_value,
    output logic                          o_last_of_frame
);

    localparam int DEPTH = MAX_COLS / 2;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = SAMPLE_BITS + 1;   // pair partial: sum of two samples
    localparam int SW    = SAMPLE_BITS + 2;   // window sum

    // stage enables: each stage moves when the one after it is empty or moving
    logic en_out, en2, en1, w_accept;

    // sequencer
    logic          w_mode;
    t_pos          w_pos;
    logic [IW-1:0] w_idx;

    // stage 1: registered input item
    logic                          r1_v;
    logic signed [SAMPLE_BITS-1:0] r1_sample;
    t_pos                          r1_pos;
    logic [IW-1:0]                 r1_idx;
    logic signed [SAMPLE_BITS-1:0] r_pair_hold;

    // stage 2: pair result plus line store entry
    logic                          r2_v;
    logic signed [PW-1:0]          r2_pair;
    logic                          r2_last;
    logic [PW-1:0]                 w_rdata;

    // result register
    logic                          r_out_v;
    logic signed [OUT_BITS-1:0]    r_out_val;
    logic                          r_out_last;

    logic signed [PW-1:0]          w_s_ext, w_h_ext, w_pair;
    logic                          w_s1_go, w_line_we, w_line_re;
    logic signed [PW-1:0]          w_above, w_min;
    logic signed [SW-1:0]          w_sum, w_avg, w_res;
    logic [SW+OUT_BITS-1:0]        w_res_ext;

    assign en_out   = !r_out_v || i_result_ready;
    assign en2      = !r2_v || en_out;
    assign en1      = !r1_v || en2;
    assign w_accept = i_sample_valid && en1;

    assign o_sample_ready = en1;

    p2ma_seq #(
        .MAX_COLS (MAX_COLS),
        .IW       (IW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (w_accept),
        .o_mode      (w_mode),
        .o_pos       (w_pos),
        .o_idx       (w_idx)
    );

    // ---------------- stage 1 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en1) begin
            r1_v <= i_sample_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r1_sample <= i_sample;
            r1_pos    <= w_pos;
            r1_idx    <= w_idx;
        end
    end

    // item leaves stage 1 this cycle
    assign w_s1_go = r1_v && en2;

    // pair partial: the held even-column sample with this odd-column one
    always_comb begin
        w_s_ext = {r1_sample[SAMPLE_BITS-1], r1_sample};
        w_h_ext = {r_pair_hold[SAMPLE_BITS-1], r_pair_hold};
        if (w_mode == MODE_MIN) begin
            w_pair = (w_s_ext < w_h_ext) ? w_s_ext : w_h_ext;
        end else begin
            w_pair = w_s_ext + w_h_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_hold <= '0;
        end else if (w_s1_go && !r1_pos.odd_col) begin
            r_pair_hold <= r1_sample;
        end
    end

    // even rows store the pair, odd rows fetch the one stored above
    assign w_line_we = w_s1_go && r1_pos.odd_col && !r1_pos.odd_row;
    assign w_line_re = w_s1_go && r1_pos.odd_col &&  r1_pos.odd_row;

    p2ma_line #(
        .DEPTH (DEPTH),
        .IW    (IW),
        .DW    (PW)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (w_line_we),
        .i_waddr (r1_idx),
        .i_wdata (w_pair),
        .i_re    (w_line_re),
        .i_raddr (r1_idx),
        .o_rdata (w_rdata)
    );

    // ---------------- stage 2 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en2) begin
            r2_v <= w_line_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_line_re) begin
            r2_pair <= w_pair;
            r2_last <= r1_pos.last;
        end
    end

    // combine with the row above; average is floor(sum / 4)
    always_comb begin
        w_above   = $signed(w_rdata);
        w_min     = (w_above < r2_pair) ? w_above : r2_pair;
        w_sum     = {w_above[PW-1], w_above} + {r2_pair[PW-1], r2_pair};
        w_avg     = w_sum >>> 2;
        w_res     = (w_mode == MODE_MIN) ? {w_min[PW-1], w_min} : w_avg;
        w_res_ext = {{OUT_BITS{w_res[SW-1]}}, w_res};
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en_out) begin
            r_out_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r2_v) begin
            r_out_val  <= $signed(w_res_ext[OUT_BITS-1:0]);
            r_out_last <= r2_last;
        end
    end

    assign o_result_valid  = r_out_v;
    assign o_pooled_value  = r_out_val;
    assign o_last_of_frame = r_out_last;

endmodule

@@ hw/rtl/p2ma_chk.sv @@
`include "pool_2x2_min_or_average_top_assert.svh"

module p2ma_chk
    import p2ma_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_sample_ready,
    input logic                       o_result_valid,
    input logic                       i_result_ready,
    input logic signed [OUT_BITS-1:0] o_pooled_value,
    input logic                       o_last_of_frame
);

    // a waiting result keeps its value
    `P2MA_ASSERT(a_out_hold, o_result_valid && !i_result_ready |=> o_result_valid && $stable(o_pooled_value) && $stable(o_last_of_frame), "stalled result changed")

    // reset empties the result register
    `P2MA_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_result_valid, "result valid after reset")

    // with the result register empty the whole pipe can move
    `P2MA_ASSERT(a_ready_free, !o_result_valid |-> o_sample_ready, "input blocked with empty output")

endmodule

bind pool_2x2_min_or_average_top p2ma_chk u_p2ma_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_sample_ready  (o_sample_ready),
    .o_result_valid  (o_result_valid),
    .i_result_ready  (i_result_ready),
    .o_pooled_value  (o_pooled_value),
    .o_last_of_frame (o_last_of_frame)
);
